>>> design/prs_pkg.sv
package prs_pkg;

  localparam int PRICE_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int LOG_FRAC   = 24;
  localparam int MANT_BITS  = 31;
  localparam int LOG_BITS   = 29;
  localparam int DIVD_BITS  = PRICE_BITS + FRAC_BITS;
  localparam int MUL_BITS   = 32;
  localparam int LN_SHIFT   = LOG_FRAC + 32 - FRAC_BITS;

  localparam logic [31:0] LN2_Q32 = 32'd2977044471;
  localparam logic [4:0]  TOP_EXP = 5'd30;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_FIRST   = 2'd1,
    ST_INVALID = 2'd2,
    ST_SAT     = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_NORM = 6'b000010,
    S_LOG  = 6'b000100,
    S_MUL  = 6'b001000,
    S_DIV  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

endpackage

>>> design/price_return_stream.sv
// Price return stream.
// Input channel (in_): one price per transfer; tdata is the signed Q16.16 price,
// tuser bit 0 marks the first price of a new series.
// Output channel (out_): one result per input transfer; tdata is the signed
// Q16.16 return, tuser is the status (0 valid, 1 first, 2 invalid, 3 saturated).
// Configuration channel (cfg_): one-bit mode, 0 log return, 1 simple return;
// always ready, write only while the block is idle.
// One item is in flight at a time; in_tready is high only while idle, so the next
// transfer can come in the same cycle that out_tvalid rises.
// A first or invalid item goes straight to the output register; a simple return
// runs a one-bit-per-cycle restoring divider, and a log return runs two
// normalizations and two squaring loops on one shared 32x32 multiplier.
// The result sits in an output register; while out_tready is low the block
// finishes the next item and then holds it until the register frees up.
// Reset clears the mode to log return, the previous price and the series
// history; the first item after reset counts as a series start.
module price_return_stream (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] price
  input  logic [0:0]  in_tuser,   // [0] series_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] return_value
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data    // [0] return_mode
);
  import prs_pkg::*;

  state_t                 state_r, state_nxt;
  logic [5:0]             cnt_r, cnt_nxt;
  logic                   sel_r, sel_nxt;
  logic                   mode_r, mode_nxt;
  logic                   have_r, have_nxt;
  logic [PRICE_BITS-1:0]  prev_r, prev_nxt;
  logic [PRICE_BITS-1:0]  pop_r, pop_nxt;
  logic [MANT_BITS-1:0]   m_r, m_nxt;
  logic [LOG_BITS-1:0]    r_r, r_nxt;
  logic [LOG_BITS-1:0]    lc_r, lc_nxt;
  logic [DIVD_BITS-1:0]   q_r, q_nxt;
  logic [31:0]            rem_r, rem_nxt;
  logic [31:0]            den_r, den_nxt;
  logic                   neg_r, neg_nxt;
  logic [DIVD_BITS-1:0]   mag_r, mag_nxt;
  status_t                stat_r, stat_nxt;
  logic                   ov_r, ov_nxt;
  logic [31:0]            od_r, od_nxt;
  status_t                os_r, os_nxt;

  logic                   in_fire;
  logic                   first;
  logic [32:0]            diff;
  logic [31:0]            dmag;
  logic [4:0]             sh;
  logic [MANT_BITS-1:0]   top_chk;
  logic [MUL_BITS-1:0]    mul_a, mul_b;
  logic [2*MUL_BITS-1:0]  prod;
  logic [31:0]            m2;
  logic [LOG_BITS-1:0]    d;
  logic [32:0]            trial;
  logic [DIVD_BITS-1:0]   lim;
  logic [31:0]            mag32;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = os_r;

  assign first   = in_tuser[0] || !have_r;
  assign diff    = {in_tdata[31], in_tdata} - {prev_r[31], prev_r};
  assign dmag    = diff[32] ? 32'(-diff) : diff[31:0];
  assign sh      = 5'd16 >> cnt_r[2:0];
  assign top_chk = m_r >> (5'd31 - sh);
  assign d       = (lc_r >= r_r) ? (lc_r - r_r) : (r_r - lc_r);

  // shared multiplier: mantissa squaring or scaling by ln2
  assign mul_a = (state_r == S_LOG) ? {1'b0, m_r} : {{(MUL_BITS-LOG_BITS){1'b0}}, d};
  assign mul_b = (state_r == S_LOG) ? {1'b0, m_r} : LN2_Q32;
  assign prod  = {{MUL_BITS{1'b0}}, mul_a} * {{MUL_BITS{1'b0}}, mul_b};
  assign m2    = prod[61:30];

  assign trial = {rem_r, q_r[DIVD_BITS-1]} - {1'b0, den_r};
  assign lim   = neg_r ? DIVD_BITS'(33'h080000000) : DIVD_BITS'(33'h07fffffff);
  assign mag32 = (mag_r > lim) ? lim[31:0] : mag_r[31:0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    mode_nxt  = mode_r;
    have_nxt  = have_r;
    prev_nxt  = prev_r;
    pop_nxt   = pop_r;
    m_nxt     = m_r;
    r_nxt     = r_r;
    lc_nxt    = lc_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    stat_nxt  = stat_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    os_nxt    = os_r;

    if (cfg_valid && cfg_ready) begin
      mode_nxt = cfg_data[0];
    end
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          prev_nxt  = in_tdata;
          have_nxt  = 1'b1;
          pop_nxt   = prev_r;
          neg_nxt   = 1'b0;
          mag_nxt   = '0;
          cnt_nxt   = '0;
          sel_nxt   = 1'b0;
          if (first) begin
            stat_nxt  = ST_FIRST;
            state_nxt = S_EMIT;
          end else if (!mode_r) begin
            if (in_tdata[31] || in_tdata == '0 || prev_r[31] || prev_r == '0) begin
              stat_nxt  = ST_INVALID;
              state_nxt = S_EMIT;
            end else begin
              m_nxt     = in_tdata[MANT_BITS-1:0];
              r_nxt     = LOG_BITS'(TOP_EXP);
              state_nxt = S_NORM;
            end
          end else begin
            if (prev_r == '0) begin
              stat_nxt  = ST_INVALID;
              state_nxt = S_EMIT;
            end else begin
              q_nxt     = {dmag, {FRAC_BITS{1'b0}}};
              rem_nxt   = '0;
              den_nxt   = prev_r[31] ? 32'(-prev_r) : prev_r;
              neg_nxt   = (diff[32] != prev_r[31]) && (dmag != '0);
              state_nxt = S_DIV;
            end
          end
        end
      end
      S_NORM: begin
        if (top_chk == '0) begin
          m_nxt = m_r << sh;
          r_nxt = r_r - LOG_BITS'(sh);
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd4) begin
          cnt_nxt   = '0;
          state_nxt = S_LOG;
        end
      end
      S_LOG: begin
        r_nxt   = {r_r[LOG_BITS-2:0], m2[31]};
        m_nxt   = m2[31] ? m2[31:1] : m2[30:0];
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(LOG_FRAC - 1)) begin
          cnt_nxt = '0;
          if (!sel_r) begin
            lc_nxt    = r_nxt;
            sel_nxt   = 1'b1;
            m_nxt     = pop_r[MANT_BITS-1:0];
            r_nxt     = LOG_BITS'(TOP_EXP);
            state_nxt = S_NORM;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        neg_nxt   = lc_r < r_r;
        mag_nxt   = DIVD_BITS'(prod >> LN_SHIFT);
        stat_nxt  = ST_VALID;
        state_nxt = S_EMIT;
      end
      S_DIV: begin
        if (!trial[32]) begin
          rem_nxt = trial[31:0];
          q_nxt   = {q_r[DIVD_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[30:0], q_r[DIVD_BITS-1]};
          q_nxt   = {q_r[DIVD_BITS-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(DIVD_BITS - 1)) begin
          cnt_nxt   = '0;
          mag_nxt   = q_nxt;
          stat_nxt  = ST_VALID;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          od_nxt    = neg_r ? 32'(-mag32) : mag32;
          os_nxt    = (mag_r > lim) ? ST_SAT : stat_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      sel_r   <= 1'b0;
      mode_r  <= 1'b0;
      have_r  <= 1'b0;
      prev_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
      mode_r  <= mode_nxt;
      have_r  <= have_nxt;
      prev_r  <= prev_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pop_r  <= pop_nxt;
    m_r    <= m_nxt;
    r_r    <= r_nxt;
    lc_r   <= lc_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
    mag_r  <= mag_nxt;
    stat_r <= stat_nxt;
    od_r   <= od_nxt;
    os_r   <= os_nxt;
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("accepted a second item while busy");

  a_norm_mantissa: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOG |-> m_r[MANT_BITS-1])
    else $error("log mantissa not normalized");

  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FIRST || out_tuser == ST_INVALID) |-> out_tdata == '0)
    else $error("nonzero value with first or invalid status");

  a_log_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && !mode_r && stat_r == ST_VALID && $past(state_r) == S_MUL
      |-> mag_r < DIVD_BITS'(33'h07fffffff))
    else $error("log return out of range");

endmodule

>>> tb/sv/price_return_stream_tb.sv
module price_return_stream_tb;
  import prs_pkg::*;

  typedef struct packed {
    logic [31:0] price;
    logic        series_start;
  } price_item_t;

  typedef struct packed {
    logic [31:0] value;
    status_t     status;
  } return_item_t;

  localparam logic MODE_LOG    = 1'b0;
  localparam logic MODE_SIMPLE = 1'b1;
  localparam int   IDLE_LIMIT  = 4000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_data;

  price_return_stream DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  price_item_t  price_queue[$];
  return_item_t return_queue[$];
  logic         mode_model;
  logic [31:0]  last_price;
  logic         have_last;
  int           fail_count;
  int           sent_count;
  int           recv_count;
  int           sat_count;
  int           invalid_count;
  int           hold_cycles;
  int           in_gap;
  int           out_gap;
  int           idle_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [63:0] log2_q24(logic [63:0] x);
    int          e;
    logic [63:0] m;
    logic [63:0] r;
    e = 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    if (e <= 30) m = x << (30 - e);
    else m = x >> (e - 30);
    r = 64'(e);
    for (int i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> 30;
      r = r << 1;
      if (m >= (64'd1 << 31)) begin
        r = r | 64'd1;
        m = m >> 1;
      end
    end
    return r;
  endfunction

  function automatic return_item_t clamp_return(logic neg, logic [63:0] mag, status_t st);
    return_item_t res;
    logic [63:0]  lim;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (mag > lim) begin
      mag = lim;
      st = ST_SAT;
    end
    res.value  = neg ? 32'(64'd0 - mag) : mag[31:0];
    res.status = st;
    return res;
  endfunction

  function automatic return_item_t predict_return(price_item_t it);
    logic signed [63:0] cur;
    logic signed [63:0] prev;
    logic signed [63:0] diff;
    logic [63:0]        lc;
    logic [63:0]        lp;
    logic [63:0]        d;
    logic [63:0]        dmag;
    logic [63:0]        den;
    logic               neg;
    logic               first;
    cur   = 64'(signed'(it.price));
    prev  = 64'(signed'(last_price));
    first = it.series_start || !have_last;
    last_price = it.price;
    have_last  = 1'b1;
    if (first) return clamp_return(1'b0, 64'd0, ST_FIRST);
    if (mode_model == MODE_LOG) begin
      if (cur <= 0 || prev <= 0) return clamp_return(1'b0, 64'd0, ST_INVALID);
      lc  = log2_q24(cur);
      lp  = log2_q24(prev);
      neg = lc < lp;
      d   = neg ? lp - lc : lc - lp;
      return clamp_return(neg, (d * 64'(LN2_Q32)) >> LN_SHIFT, ST_VALID);
    end
    if (prev == 0) return clamp_return(1'b0, 64'd0, ST_INVALID);
    diff = cur - prev;
    dmag = diff < 0 ? 64'(-diff) : 64'(diff);
    den  = prev < 0 ? 64'(-prev) : 64'(prev);
    neg  = (diff < 0) != (prev < 0);
    if (dmag == 0) neg = 1'b0;
    return clamp_return(neg, (dmag << FRAC_BITS) / den, ST_VALID);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      in_gap    <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) sent_count <= sent_count + 1;
      if (in_tvalid && in_tready) begin
        return_queue.push_back(predict_return('{in_tdata, in_tuser[0]}));
      end
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap    <= in_gap - 1;
      end else if (price_queue.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= price_queue[0].price;
        in_tuser  <= price_queue[0].series_start;
        void'(price_queue.pop_front());
        in_gap    <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    return_item_t exp_item;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        recv_count <= recv_count + 1;
        if (return_queue.size() == 0) begin
          $display("%0t: unexpected result value=%h status=%0d", $time, out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          exp_item = return_queue.pop_front();
          if (exp_item.value !== out_tdata || exp_item.status !== out_tuser) begin
            $display("%0t: mismatch expected value=%h status=%0d actual value=%h status=%0d",
                     $time, exp_item.value, exp_item.status, out_tdata, out_tuser);
            fail_count <= fail_count + 1;
          end
          if (exp_item.status == ST_SAT) sat_count <= sat_count + 1;
          if (exp_item.status == ST_INVALID) invalid_count <= invalid_count + 1;
        end
      end
      if (hold_cycles > 0) begin
        out_tready  <= 1'b0;
        hold_cycles <= hold_cycles - 1;
      end else if (out_tvalid && out_tready) begin
        out_gap    <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_tready <= 1'b0;
        out_gap    <= out_gap - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("price_return_stream_tb failed");
      $finish;
    end
  end

  task automatic add_price(logic [31:0] p, logic s);
    price_queue.push_back('{p, s});
  endtask

  task automatic drain_all();
    while (price_queue.size() > 0 || in_tvalid || return_queue.size() > 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    mode_model = m;
  endtask

  task automatic add_random_prices(int n);
    logic [31:0] base;
    int          r;
    base = 32'h0001_0000;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0) add_price($urandom, 1'($urandom_range(0, 1)));
      else if (r == 1) begin
        add_price($urandom_range(0, 3) == 0 ? 32'd0 : 32'($urandom_range(1, 40)), 1'b0);
      end else begin
        if ($urandom_range(0, 15) == 0) base = $urandom_range(1, 32'h7FFF_FFFF);
        base = base + 32'(signed'($urandom_range(0, 2000)) - 1000) * ($urandom_range(1, 64));
        if ($urandom_range(0, 12) == 0) base = -base;
        add_price(base, $urandom_range(0, 30) == 0);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mode_model = MODE_LOG;
    last_price = '0;
    have_last = 1'b0;
    fail_count = 0;
    sent_count = 0;
    recv_count = 0;
    sat_count = 0;
    invalid_count = 0;
    hold_cycles = 0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    add_price(32'h0001_0000, 1'b0);
    add_price(32'h0002_0000, 1'b0);
    add_price(32'h7FFF_FFFF, 1'b0);
    add_price(32'h0000_0001, 1'b0);
    add_price(32'h7FFF_FFFF, 1'b0);
    add_price(32'h0000_0000, 1'b0);
    add_price(32'h0001_0000, 1'b0);
    add_price(32'h8000_0000, 1'b0);
    add_price(32'hFFFF_FFFF, 1'b1);
    add_price(32'h0001_8000, 1'b0);
    drain_all();
    write_mode(MODE_SIMPLE);
    add_price(32'h0001_0000, 1'b1);
    add_price(32'h0001_0000, 1'b0);
    add_price(32'h0000_0001, 1'b0);
    add_price(32'h7FFF_FFFF, 1'b0);
    add_price(32'h8000_0000, 1'b0);
    add_price(32'h7FFF_FFFF, 1'b0);
    add_price(32'h0000_0000, 1'b0);
    add_price(32'h0003_0000, 1'b0);
    add_price(32'hFFFF_0000, 1'b0);
    add_price(32'hFFFE_0000, 1'b0);
    add_price(32'h0000_0005, 1'b1);
    drain_all();
    write_mode(MODE_LOG);
    add_random_prices(200);
    @(posedge clk);
    hold_cycles = 600;
    drain_all();
    for (int ph = 0; ph < 6; ph++) begin
      write_mode(ph[0] ? MODE_LOG : MODE_SIMPLE);
      add_random_prices(210);
      drain_all();
    end

    $display("covered %0d prices, %0d results, %0d invalid, %0d saturated, both modes",
             sent_count, recv_count, invalid_count, sat_count);
    if (fail_count == 0) $display("price_return_stream_tb passed");
    else $display("price_return_stream_tb failed");
    $finish;
  end
endmodule
